@@ sv/mh_pkg.sv @@
package mh_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int SCALE_SH = 14;
    localparam int XY_W     = DIFF_W + SCALE_SH + 3;
    localparam int ACC_W    = 32;
    localparam int HEAD_W   = 16;
    localparam int PROD_W   = ACC_W + HEAD_W;

    // One turn in hundredths of a degree
    localparam logic [HEAD_W-1:0] TURN_HUNDREDTHS = 16'd36000;

    // Half a turn in accumulator units
    localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_X_OFFSET    = 2'd0;
    localparam t_cfg_index CFG_Y_OFFSET    = 2'd1;
    localparam t_cfg_index CFG_DECLINATION = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] DECLINATION_RESET = 16'sd443;

    // atan(2^-i) in units of 2^-32 turn
    localparam int TABLE_LEN = 24;
    localparam logic [ACC_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    // Word handed from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [ACC_W-1:0]       acc;
        logic                   zero;
    } t_cordic_word;

endpackage

@@ sv/magnetometer_heading.sv @@
// An accepted word passes the prep register, the CORDIC cells and mh_convert to
// m_axis. Throughput: one word per cycle while m_axis is ready; each CORDIC
// iteration is its own cell. Stalls on m_axis fill bubbles in the chain before
// s_axis_tready drops. Reset (i_rst_n low at a clock edge) empties the chain and
// sets both offsets to 0 and declination to 4.43 degrees.
module magnetometer_heading #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,  // raw_x[15:0], raw_y[31:16]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // heading[15:0]
    input  logic                               i_cfg_wr_en,
    input  mh_pkg::t_cfg_index                 i_cfg_index,
    input  logic [mh_pkg::SAMPLE_W-1:0]        i_cfg_data
);

    localparam int NCELL = (CORDIC_STEPS < mh_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                              : mh_pkg::TABLE_LEN;

    logic signed [mh_pkg::SAMPLE_W-1:0] r_x_offset;
    logic signed [mh_pkg::SAMPLE_W-1:0] r_y_offset;
    logic signed [mh_pkg::SAMPLE_W-1:0] r_declination;

    logic                               r_prep_valid;
    mh_pkg::t_cordic_word               r_prep_word;
    mh_pkg::t_cordic_word               n_prep_word;
    logic                               w_prep_ready;

    logic signed [mh_pkg::SAMPLE_W-1:0] w_raw_x;
    logic signed [mh_pkg::SAMPLE_W-1:0] w_raw_y;
    logic signed [mh_pkg::DIFF_W-1:0]   w_dx;
    logic signed [mh_pkg::DIFF_W-1:0]   w_dy;
    logic signed [mh_pkg::DIFF_W-1:0]   w_px;
    logic signed [mh_pkg::DIFF_W-1:0]   w_py;

    logic                               w_valid [NCELL+1];
    logic                               w_ready [NCELL+1];
    mh_pkg::t_cordic_word               w_word  [NCELL+1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset    <= '0;
            r_y_offset    <= '0;
            r_declination <= mh_pkg::DECLINATION_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mh_pkg::CFG_X_OFFSET:    r_x_offset    <= i_cfg_data;
                mh_pkg::CFG_Y_OFFSET:    r_y_offset    <= i_cfg_data;
                mh_pkg::CFG_DECLINATION: r_declination <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Remove hard-iron offsets, fold the left half plane and scale up
    always_comb begin
        w_raw_x = s_axis_tdata[15:0];
        w_raw_y = s_axis_tdata[31:16];
        w_dx = {w_raw_x[mh_pkg::SAMPLE_W-1], w_raw_x}
             - {r_x_offset[mh_pkg::SAMPLE_W-1], r_x_offset};
        w_dy = {w_raw_y[mh_pkg::SAMPLE_W-1], w_raw_y}
             - {r_y_offset[mh_pkg::SAMPLE_W-1], r_y_offset};
        w_px = w_dx[mh_pkg::DIFF_W-1] ? -w_dx : w_dx;
        w_py = w_dx[mh_pkg::DIFF_W-1] ? -w_dy : w_dy;
        n_prep_word.x = {{(mh_pkg::XY_W-mh_pkg::DIFF_W-mh_pkg::SCALE_SH){w_px[mh_pkg::DIFF_W-1]}},
                         w_px, {mh_pkg::SCALE_SH{1'b0}}};
        n_prep_word.y = {{(mh_pkg::XY_W-mh_pkg::DIFF_W-mh_pkg::SCALE_SH){w_py[mh_pkg::DIFF_W-1]}},
                         w_py, {mh_pkg::SCALE_SH{1'b0}}};
        n_prep_word.acc  = w_dx[mh_pkg::DIFF_W-1] ? mh_pkg::HALF_TURN : '0;
        n_prep_word.zero = (w_dx == '0) && (w_dy == '0);
    end

    assign w_prep_ready  = !r_prep_valid || w_ready[0];
    assign s_axis_tready = w_prep_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (w_prep_ready) begin
            r_prep_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && w_prep_ready) begin
            r_prep_word <= n_prep_word;
        end
    end

    assign w_valid[0] = r_prep_valid;
    assign w_word[0]  = r_prep_word;

    // Chain of CORDIC cells, one iteration each
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        mh_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_word  (w_word[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_word  (w_word[g+1])
        );
    end

    // Angle to heading
    mh_convert u_convert (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid[NCELL]),
        .o_ready       (w_ready[NCELL]),
        .i_word        (w_word[NCELL]),
        .i_declination (r_declination),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_heading     (m_axis_tdata)
    );

endmodule

@@ sv/mh_cordic_cell.sv @@
module mh_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mh_pkg::t_cordic_word i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mh_pkg::t_cordic_word o_word
);

    logic                        r_valid;
    mh_pkg::t_cordic_word        r_word;
    mh_pkg::t_cordic_word        n_word;
    logic signed [mh_pkg::XY_W-1:0] w_x;
    logic signed [mh_pkg::XY_W-1:0] w_y;
    logic signed [mh_pkg::XY_W-1:0] w_xs;
    logic signed [mh_pkg::XY_W-1:0] w_ys;
    logic                        w_load;

    // Take a new word when empty or when the neighbour drains this one
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // Rotate towards the x axis by one micro-angle
    always_comb begin
        w_x  = i_word.x;
        w_y  = i_word.y;
        w_xs = w_x >>> STEP;
        w_ys = w_y >>> STEP;
        n_word = i_word;
        if (!w_y[mh_pkg::XY_W-1] && (w_y != '0)) begin
            n_word.x   = w_x + w_ys;
            n_word.y   = w_y - w_xs;
            n_word.acc = i_word.acc + mh_pkg::ATAN_TURNS[STEP];
        end else begin
            n_word.x   = w_x - w_ys;
            n_word.y   = w_y + w_xs;
            n_word.acc = i_word.acc - mh_pkg::ATAN_TURNS[STEP];
        end
    end

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ sv/mh_convert.sv @@
module mh_convert (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  mh_pkg::t_cordic_word               i_word,
    input  logic signed [mh_pkg::SAMPLE_W-1:0] i_declination,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [mh_pkg::HEAD_W-1:0]          o_heading
);

    localparam int SUM_W = mh_pkg::HEAD_W + 2;

    logic                             r_a_valid;
    logic [mh_pkg::PROD_W-1:0]        r_prod;
    logic                             r_a_zero;
    logic                             w_a_ready;
    logic                             r_b_valid;
    logic [mh_pkg::HEAD_W-1:0]        r_heading;
    logic                             w_b_ready;
    logic [mh_pkg::PROD_W-1:0]        w_round;
    logic [mh_pkg::HEAD_W-1:0]        w_h;
    logic [mh_pkg::HEAD_W-1:0]        w_hfix;
    logic signed [SUM_W-1:0]          w_sum;
    logic signed [SUM_W-1:0]          w_turn;
    logic signed [SUM_W-1:0]          w_sum_lo;
    logic signed [SUM_W-1:0]          w_sum_hi;
    logic [mh_pkg::HEAD_W-1:0]        n_heading;

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    // Scale the angle to hundredths of a degree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_a_ready) begin
            r_prod   <= mh_pkg::PROD_W'(i_word.acc)
                      * mh_pkg::PROD_W'(mh_pkg::TURN_HUNDREDTHS);
            r_a_zero <= i_word.zero;
        end
    end

    // Round, fold a full turn or a zero vector to zero, add declination and wrap
    always_comb begin
        w_round  = r_prod + mh_pkg::PROD_W'(mh_pkg::HALF_TURN);
        w_h      = w_round[mh_pkg::PROD_W-1:mh_pkg::ACC_W];
        w_hfix   = (r_a_zero || (w_h >= mh_pkg::TURN_HUNDREDTHS)) ? '0 : w_h;
        w_turn   = $signed({2'b00, mh_pkg::TURN_HUNDREDTHS});
        w_sum    = $signed({2'b00, w_hfix})
                 + $signed({{2{i_declination[mh_pkg::SAMPLE_W-1]}}, i_declination});
        w_sum_lo = w_sum + w_turn;
        w_sum_hi = w_sum - w_turn;
        if (w_sum[SUM_W-1]) begin
            n_heading = w_sum_lo[mh_pkg::HEAD_W-1:0];
        end else if (w_sum >= w_turn) begin
            n_heading = w_sum_hi[mh_pkg::HEAD_W-1:0];
        end else begin
            n_heading = w_sum[mh_pkg::HEAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && w_b_ready) begin
            r_heading <= n_heading;
        end
    end

    assign o_valid   = r_b_valid;
    assign o_heading = r_heading;

endmodule
